@@ rtl/icdc_pkg.sv @@
// ----------------------------------------------------------------------------
// icdc_pkg
// Shared widths, limits and status types of the two-wire bus clock divider
// calculator.
// ----------------------------------------------------------------------------
package icdc_pkg;

  // operand and quotient width
  localparam int DIV_W   = 32;
  localparam int STEP_W  = $clog2(DIV_W);
  // base count is the quotient halved once
  localparam int CNT_W   = DIV_W - 1;

  // prescaled count limit and exponent limit
  localparam int           PCNT_W    = 8;
  localparam int           EXP_W     = 3;
  localparam logic [7:0]   COUNT_MAX = 8'hFF;
  localparam logic [2:0]   EXP_MAX   = 3'h7;

  // result field widths
  localparam int LOW_W   = 7;
  localparam int HIGH_W  = 8;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // status of a multi-cycle unit toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

@@ rtl/icdc_req_if.sv @@
// ----------------------------------------------------------------------------
// icdc_req_if
// Request channel: bus clock and target clock frequencies, valid/ready.
// ----------------------------------------------------------------------------
interface icdc_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] bus_clock_hz;
  logic [31:0] target_clock_hz;

  modport source (output valid, output bus_clock_hz, output target_clock_hz,
                  input ready);
  modport sink   (input valid, input bus_clock_hz, input target_clock_hz,
                  output ready);
endinterface

@@ rtl/icdc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// icdc_rsp_if
// Result channel: status and clock waveform settings, valid/ready.
// ----------------------------------------------------------------------------
interface icdc_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [6:0] low_count;
  logic [7:0] high_count;
  logic [7:0] start_stop_hold;
  logic       data_hold;
  logic [2:0] prescale_exponent;

  modport source (output valid, output status, output low_count,
                  output high_count, output start_stop_hold,
                  output data_hold, output prescale_exponent, input ready);
  modport sink   (input valid, input status, input low_count,
                  input high_count, input start_stop_hold,
                  input data_hold, input prescale_exponent, output ready);
endinterface

@@ rtl/icdc_div.sv @@
// ----------------------------------------------------------------------------
// icdc_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icdc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [icdc_pkg::DIV_W-1:0] dividend,
  input  logic [icdc_pkg::DIV_W-1:0] divisor,
  output logic [icdc_pkg::DIV_W-1:0] quotient,
  output icdc_pkg::unit_stat_t       stat
);
  import icdc_pkg::*;

  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DIV_W+1:0]  diff;
  logic              qbit;
  logic [DIV_W-1:0]  rem_next;

  // trial subtract of the shifted partial remainder
  always_comb begin
    diff     = {1'b0, rem, quo[DIV_W-1]} - {2'b00, dvs};
    qbit     = ~diff[DIV_W+1];
    rem_next = qbit ? diff[DIV_W-1:0] : {rem[DIV_W-2:0], quo[DIV_W-1]};
  end

  // dividend shifts out the top as quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[DIV_W-2:0], qbit};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ rtl/icdc_scale.sv @@
// ----------------------------------------------------------------------------
// icdc_scale
// Prescaler search: halves the base count one step a cycle until it fits
// in 8 bits, counting the exponent; flags overflow past the top exponent.
// ----------------------------------------------------------------------------
module icdc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [icdc_pkg::DIV_W-1:0]  quotient,
  output logic                        err,
  output logic [icdc_pkg::PCNT_W-1:0] pcount,
  output logic [icdc_pkg::EXP_W-1:0]  exponent,
  output icdc_pkg::unit_stat_t        stat
);
  import icdc_pkg::*;

  logic [CNT_W-1:0] count;
  logic [EXP_W-1:0] exp_q;
  logic             busy;
  logic             done;
  logic             fits;

  assign fits = ~|count[CNT_W-1:PCNT_W];

  // one halving per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      err  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= quotient[DIV_W-1:1];
        exp_q <= '0;
        err   <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (exp_q == EXP_MAX) begin
          // count still too wide after the last halving allowed
          err  <= 1'b1;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= {1'b0, count[CNT_W-1:1]};
          exp_q <= exp_q + 1'b1;
        end
      end
    end
  end

  assign pcount    = count[PCNT_W-1:0];
  assign exponent  = exp_q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ rtl/i2c_clock_divider_calc.sv @@
// ----------------------------------------------------------------------------
// i2c_clock_divider_calc
// Two-wire bus clock divider calculator: bus and target frequency in,
// low/high periods, start/stop hold and prescaler exponent out.
// ----------------------------------------------------------------------------
// One request is worked on at a time. After acceptance a request runs
// through the bit-serial divider forming bus/target, then the prescaler
// search, which halves the count once per cycle, then hands off to the
// output register. A zero target skips both units and goes straight to the
// hold state, where it yields an error result. A result still waiting in
// the output register holds off the load of the next one. The output
// register decouples the result channel, so a new request is taken as soon
// as the previous result has been moved there. Error results carry status
// 1 and all other fields zero; data_hold is always zero.
// ----------------------------------------------------------------------------
module i2c_clock_divider_calc (
  input  logic       clk,
  input  logic       rst,
  icdc_req_if.sink   req,
  icdc_rsp_if.source rsp
);
  import icdc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_HOLD
  } state_t;

  state_t           state;
  logic             zero_tgt;
  logic             accept;
  logic             div_start;
  logic [DIV_W-1:0] quotient;
  unit_stat_t       div_stat;
  logic             scale_err;
  logic [PCNT_W-1:0] pcount;
  logic [EXP_W-1:0] exponent;
  unit_stat_t       scale_stat;
  logic             res_err;
  logic             out_load;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid & req.ready;
  assign div_start = accept & (req.target_clock_hz != '0);
  assign res_err   = zero_tgt | scale_err;
  assign out_load  = (state == ST_HOLD) & (~rsp.valid | rsp.ready);

  icdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.bus_clock_hz),
    .divisor  (req.target_clock_hz),
    .quotient (quotient),
    .stat     (div_stat)
  );

  icdc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .start    (div_stat.done),
    .quotient (quotient),
    .err      (scale_err),
    .pcount   (pcount),
    .exponent (exponent),
    .stat     (scale_stat)
  );

  // control sequence and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      zero_tgt  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !out_load) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            zero_tgt <= (req.target_clock_hz == '0);
            state    <= (req.target_clock_hz == '0) ? ST_HOLD : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (scale_stat.done) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            rsp.valid <= 1'b1;
            rsp.data_hold <= 1'b0;
            if (res_err) begin
              rsp.status            <= STATUS_ERR;
              rsp.low_count         <= '0;
              rsp.high_count        <= '0;
              rsp.start_stop_hold   <= '0;
              rsp.prescale_exponent <= '0;
            end else begin
              rsp.status            <= STATUS_OK;
              rsp.low_count         <= pcount[PCNT_W-1:1];
              rsp.high_count        <= pcount - {1'b0, pcount[PCNT_W-1:1]};
              rsp.start_stop_hold   <= pcount;
              rsp.prescale_exponent <= exponent;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // divider completes only while the controller waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("divider done outside divide phase");

  // a new request is only taken with both units quiet
  a_ready_idle_units: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!div_stat.busy && !scale_stat.busy))
    else $error("request ready while a unit is busy");

  // error results carry no settings
  a_err_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_ERR) |->
      (rsp.start_stop_hold == '0 && rsp.prescale_exponent == '0 &&
       rsp.low_count == '0 && rsp.high_count == '0))
    else $error("error result with nonzero fields");

  // low and high periods add up to the prescaled count
  a_ok_split: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_OK) |->
      ((PCNT_W'(rsp.low_count) + rsp.high_count) == rsp.start_stop_hold))
    else $error("low/high split does not match count");

endmodule

@@ tb/icdc_divider_check.sv @@
// ----------------------------------------------------------------------------
// icdc_divider_check
// Watches the request and result channels of the clock divider calculator,
// predicts the waveform settings of every accepted request and compares each
// accepted result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module icdc_divider_check
  import icdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  icdc_req_if         req,
  icdc_rsp_if         rsp,
  output int unsigned fail_count,
  output int unsigned pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIV_W-1:0]  bus_clock_hz;
    logic [DIV_W-1:0]  target_clock_hz;
    logic              status;
    logic [LOW_W-1:0]  low_count;
    logic [HIGH_W-1:0] high_count;
    logic [PCNT_W-1:0] start_stop_hold;
    logic              data_hold;
    logic [EXP_W-1:0]  prescale_exponent;
  } divider_settings_t;

  divider_settings_t settings_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // prescaler search: halve the base count until it fits in 8 bits
  function automatic divider_settings_t calc_divider_settings(
    input logic [DIV_W-1:0] bus_hz,
    input logic [DIV_W-1:0] target_hz
  );
    divider_settings_t s;
    logic [DIV_W-1:0]  cnt;
    int unsigned       shifts;
    s                 = '0;
    s.bus_clock_hz    = bus_hz;
    s.target_clock_hz = target_hz;
    s.status          = STATUS_ERR;
    if (target_hz == '0) begin
      return s;
    end
    cnt    = (bus_hz / target_hz) / 2;
    shifts = 0;
    while (cnt > COUNT_MAX && shifts <= EXP_MAX) begin
      shifts++;
      cnt = cnt / 2;
    end
    // count still too wide after the last allowed halving
    if (shifts > EXP_MAX) begin
      return s;
    end
    s.status            = STATUS_OK;
    s.low_count         = LOW_W'(cnt / 2);
    s.high_count        = HIGH_W'(cnt - cnt / 2);
    s.start_stop_hold   = cnt[PCNT_W-1:0];
    s.data_hold         = 1'b0;
    s.prescale_exponent = shifts[EXP_W-1:0];
    return s;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input divider_settings_t exp_s,
                               input int unsigned got, input int unsigned want);
    if (got !== want) begin
      report_error($sformatf("bus=%0d target=%0d %s got %0d expected %0d",
                             exp_s.bus_clock_hz, exp_s.target_clock_hz,
                             name, got, want));
    end
  endtask

  // sample both channels on the clock edge
  always @(posedge clk) begin
    divider_settings_t exp_s;
    if (!rst) begin
      if (req.valid && req.ready) begin
        settings_q.push_back(calc_divider_settings(req.bus_clock_hz,
                                                   req.target_clock_hz));
      end
      if (rsp.valid && rsp.ready) begin
        if (settings_q.size() == 0) begin
          report_error("result beat with no request outstanding");
        end else begin
          exp_s = settings_q.pop_front();
          compare_field("status", exp_s, rsp.status, exp_s.status);
          compare_field("low_count", exp_s, rsp.low_count, exp_s.low_count);
          compare_field("high_count", exp_s, rsp.high_count, exp_s.high_count);
          compare_field("start_stop_hold", exp_s, rsp.start_stop_hold,
                        exp_s.start_stop_hold);
          compare_field("data_hold", exp_s, rsp.data_hold, exp_s.data_hold);
          compare_field("prescale_exponent", exp_s, rsp.prescale_exponent,
                        exp_s.prescale_exponent);
        end
      end
      pending <= settings_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-wire bus clock divider calculator: a short
// directed set of frequency pairs at the count and exponent boundaries, then
// random pairs shaped to hit every prescaler exponent, under three idling
// patterns on the request and result channels.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned fail_count;
  int unsigned pending;

  icdc_req_if req_ch ();
  icdc_rsp_if rsp_ch ();

  i2c_clock_divider_calc dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  icdc_divider_check chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // one request beat; idle cycles first, then hold until accepted
  task automatic send_request(input logic [31:0] bus_hz, input logic [31:0] target_hz);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.bus_clock_hz    <= bus_hz;
    req_ch.target_clock_hz <= target_hz;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // random pair: mostly a chosen ratio so that every exponent shows up
  task automatic send_random_request();
    int unsigned       mode;
    int unsigned       ratio_bits;
    longint unsigned   ratio;
    longint unsigned   tgt;
    longint unsigned   bus;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      send_request($urandom, $urandom);
    end else if (mode == 2) begin
      send_request($urandom, $urandom_range(1, 255));
    end else if (mode == 3) begin
      send_request($urandom, 32'h0);
    end else begin
      ratio_bits = $urandom_range(0, 17);
      ratio      = $urandom_range(0, (32'h1 << ratio_bits) - 1);
      tgt        = $urandom_range(1, 32'hFFFF_FFFF / (ratio + 1));
      bus        = tgt * ratio + $urandom_range(0, tgt - 1);
      send_request(bus[31:0], tgt[31:0]);
    end
  endtask

  initial begin
    rst                    = 1'b1;
    src_idle_pct           = 7;
    sink_idle_pct          = 73;
    req_ch.valid           = 1'b0;
    req_ch.bus_clock_hz    = '0;
    req_ch.target_clock_hz = '0;
    rsp_ch.ready           = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero target
    send_request(32'h0, 32'h0);
    send_request(32'hFFFF_FFFF, 32'h0);
    // zero count, ratio below two
    send_request(32'h0, 32'h1);
    send_request(32'h1, 32'h1);
    send_request(32'h3, 32'h2);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_request(32'h0, 32'hFFFF_FFFF);
    // small counts
    send_request(32'h2, 32'h1);
    send_request(32'h3, 32'h1);
    send_request(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    // largest count with no prescaling, and the first ones past it
    send_request(32'd510, 32'h1);
    send_request(32'd511, 32'h1);
    send_request(32'd1020, 32'h2);
    send_request(32'd512, 32'h1);
    send_request(32'd1023, 32'h1);
    send_request(32'd1024, 32'h1);
    // largest count that fits at the top exponent, and the first too large
    send_request(32'd65535, 32'h1);
    send_request(32'hFFFF_FFFF, 32'h0001_0000);
    send_request(32'd65536, 32'h1);
    send_request(32'hFFFF_FFFF, 32'h0000_8000);
    send_request(32'hFFFF_FFFF, 32'h1);
    // typical bus and serial clock rates
    send_request(32'd66_000_000, 32'd100_000);
    send_request(32'd66_000_000, 32'd400_000);

    repeat (320) send_random_request();
    src_idle_pct  <= 73;
    sink_idle_pct <= 7;
    repeat (320) send_random_request();
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    repeat (310) send_random_request();
    req_ch.valid <= 1'b0;

    // drain outstanding results, then a quiet tail for stray beats
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
